[hdl/rpi_pkg.sv]
package rpi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } t_reg_idx;

endpackage

[hdl/rpi_div_cell.sv]
// One restoring-division step: shift in one numerator bit, subtract if it fits.
module rpi_div_cell import rpi_pkg::*; #(
    parameter int RW = 72,
    parameter int NW = 96,
    parameter int QW = 48,
    parameter int CW = 100
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [RW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [RW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    input  logic [CW-1:0] i_ctx,
    output logic          o_vld,
    output logic [RW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [RW-1:0] o_den,
    output logic [QW-1:0] o_quo,
    output logic [CW-1:0] o_ctx
);
    logic [RW:0] w_sh;
    logic [RW:0] w_diff;
    logic        w_ge;

    assign w_sh   = {i_rem, i_num[NW-1]};
    assign w_diff = w_sh - {1'b0, i_den};
    assign w_ge   = !w_diff[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else          o_vld <= i_vld;
        o_rem <= w_ge ? w_diff[RW-1:0] : w_sh[RW-1:0];
        o_num <= {i_num[NW-2:0], 1'b0};
        o_den <= i_den;
        o_quo <= {i_quo[QW-2:0], w_ge};
        o_ctx <= i_ctx;
    end
endmodule

[hdl/ray_plane_intersect_top.sv]
// Channel   Direction  Ports                               Handshake
// config    in         i_cfg_valid/o_cfg_ready, index,data  valid & ready
// ray       in         i_start, origin_*, dir_*            start & !busy
// result    out        o_strobe, hit..overflow             one cycle, no stall
//
// One ray enters per cycle; o_busy is always low. The dot products are
// registered in the product, sum and magnitude stages, then run through a
// chain of division cells, one per quotient bit (2*WORD_BITS+FRAC_BITS+2
// quotient bits, wide enough to cover any quotient that could exceed the
// saturation bound), then through the point products and the output
// register, which drives o_strobe. Reset clears the plane registers and
// all valid bits in the pipeline. The receiver cannot stall results.
module ray_plane_intersect_top import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [WORD_BITS-1:0] i_origin_x,
    input  logic signed [WORD_BITS-1:0] i_origin_y,
    input  logic signed [WORD_BITS-1:0] i_origin_z,
    input  logic signed [WORD_BITS-1:0] i_dir_x,
    input  logic signed [WORD_BITS-1:0] i_dir_y,
    input  logic signed [WORD_BITS-1:0] i_dir_z,
    output logic                        o_strobe,
    output logic                        o_hit,
    output logic [WORD_BITS-2:0]        o_distance,
    output logic signed [WORD_BITS-1:0] o_point_x,
    output logic signed [WORD_BITS-1:0] o_point_y,
    output logic signed [WORD_BITS-1:0] o_point_z,
    output logic                        o_overflow
);
    localparam int W   = WORD_BITS;
    localparam int PW  = 2 * W;           // one product
    localparam int DW  = PW + 2;          // sum of three products plus offset
    localparam int NW  = DW + FRAC_BITS;  // numerator scaled by 2^FRAC
    localparam int QW  = NW;              // quotient bits, one per cell
    localparam int CW  = 6 * W + 1;       // origin, dir, hit-possible
    localparam int TW  = W - 1;

    // plane registers
    logic signed [W-1:0] r_nx, r_ny, r_nz, r_off;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0; r_ny <= '0; r_nz <= '0; r_off <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_NORMAL_X:     r_nx  <= i_cfg_data;
                REG_NORMAL_Y:     r_ny  <= i_cfg_data;
                REG_NORMAL_Z:     r_nz  <= i_cfg_data;
                REG_PLANE_OFFSET: r_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: six products, register ray
    logic                r_v1;
    logic signed [PW-1:0] r_pd0, r_pd1, r_pd2, r_ps0, r_ps1, r_ps2;
    logic signed [W-1:0]  r_off1;
    logic [6*W-1:0]       r_ray1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_start;
        r_pd0  <= PW'(r_nx * i_dir_x);
        r_pd1  <= PW'(r_ny * i_dir_y);
        r_pd2  <= PW'(r_nz * i_dir_z);
        r_ps0  <= PW'(r_nx * i_origin_x);
        r_ps1  <= PW'(r_ny * i_origin_y);
        r_ps2  <= PW'(r_nz * i_origin_z);
        r_off1 <= r_off;
        r_ray1 <= {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z};
    end

    // stage 2: sums
    logic                r_v2;
    logic signed [DW-1:0] r_den, r_num;
    logic [6*W-1:0]       r_ray2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_den  <= DW'(r_pd0) + DW'(r_pd1) + DW'(r_pd2);
        r_num  <= -(DW'(r_ps0) + DW'(r_ps1) + DW'(r_ps2)
                    + (DW'(r_off1) <<< FRAC_BITS));
        r_ray2 <= r_ray1;
    end

    // stage 3: magnitudes and hit decision
    logic           r_v3;
    logic [DW-1:0]  r_anum, r_aden;
    logic [CW-1:0]  r_ctx3;
    logic           w_hitp;

    assign w_hitp = (r_den != '0) &&
                    ((r_num == '0) || (r_num[DW-1] == r_den[DW-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_anum <= r_num[DW-1] ? -r_num : r_num;
        r_aden <= r_den[DW-1] ? -r_den : r_den;
        r_ctx3 <= {w_hitp, r_ray2};
    end

    // division chain: one cell per quotient bit
    logic          c_vld [QW+1];
    logic [DW-1:0] c_rem [QW+1];
    logic [NW-1:0] c_num [QW+1];
    logic [DW-1:0] c_den [QW+1];
    logic [QW-1:0] c_quo [QW+1];
    logic [CW-1:0] c_ctx [QW+1];

    assign c_vld[0] = r_v3;
    assign c_rem[0] = '0;
    assign c_num[0] = {r_anum, {FRAC_BITS{1'b0}}};
    assign c_den[0] = r_aden;
    assign c_quo[0] = '0;
    assign c_ctx[0] = r_ctx3;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        rpi_div_cell #(.RW(DW), .NW(NW), .QW(QW), .CW(CW)) u_cell (
            .i_clk (i_clk),      .i_rst_n (i_rst_n),
            .i_vld (c_vld[g]),   .i_rem (c_rem[g]),   .i_num (c_num[g]),
            .i_den (c_den[g]),   .i_quo (c_quo[g]),   .i_ctx (c_ctx[g]),
            .o_vld (c_vld[g+1]), .o_rem (c_rem[g+1]), .o_num (c_num[g+1]),
            .o_den (c_den[g+1]), .o_quo (c_quo[g+1]), .o_ctx (c_ctx[g+1])
        );
    end

    // stage A: saturate t, products t*d
    logic [QW-1:0]        w_q;
    logic                 w_tsat;
    logic [TW-1:0]        w_t;
    logic                 r_va, r_hita, r_ovfa;
    logic [TW-1:0]        r_ta;
    logic signed [W-1:0]  r_sxa, r_sya, r_sza;
    logic signed [PW-1:0] r_mx, r_my, r_mz;
    logic [CW-1:0]        w_ctx;

    assign w_ctx  = c_ctx[QW];
    assign w_q    = c_quo[QW];
    assign w_tsat = (w_q >> TW) != '0;
    assign w_t    = w_tsat ? {TW{1'b1}} : w_q[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= c_vld[QW];
        r_hita <= w_ctx[CW-1];
        r_ovfa <= w_tsat;
        r_ta   <= w_t;
        r_sxa  <= w_ctx[6*W-1:5*W];
        r_sya  <= w_ctx[5*W-1:4*W];
        r_sza  <= w_ctx[4*W-1:3*W];
        r_mx   <= PW'($signed({1'b0, w_t}) * $signed(w_ctx[3*W-1:2*W]));
        r_my   <= PW'($signed({1'b0, w_t}) * $signed(w_ctx[2*W-1:W]));
        r_mz   <= PW'($signed({1'b0, w_t}) * $signed(w_ctx[W-1:0]));
    end

    // stage B: add origin, saturate, output register
    localparam int SW = PW + 1;
    logic signed [SW-1:0] w_px, w_py, w_pz;
    logic                 w_ox, w_oy, w_oz;
    logic signed [W-1:0]  w_cx, w_cy, w_cz;

    function automatic logic signed [W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] lo, hi;
        lo = -(SW'(1) <<< (W - 1));
        hi = (SW'(1) <<< (W - 1)) - SW'(1);
        if (v > hi)      f_sat = {1'b0, {(W-1){1'b1}}};
        else if (v < lo) f_sat = {1'b1, {(W-1){1'b0}}};
        else             f_sat = v[W-1:0];
    endfunction

    function automatic logic f_ovf(input logic signed [SW-1:0] v);
        f_ovf = (v[SW-1:W-1] != '0) && (v[SW-1:W-1] != '1);
    endfunction

    assign w_px = SW'(r_sxa) + SW'(r_mx >>> FRAC_BITS);
    assign w_py = SW'(r_sya) + SW'(r_my >>> FRAC_BITS);
    assign w_pz = SW'(r_sza) + SW'(r_mz >>> FRAC_BITS);
    assign w_ox = f_ovf(w_px);
    assign w_oy = f_ovf(w_py);
    assign w_oz = f_ovf(w_pz);
    assign w_cx = f_sat(w_px);
    assign w_cy = f_sat(w_py);
    assign w_cz = f_sat(w_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else          o_strobe <= r_va;
        o_hit      <= r_hita;
        o_distance <= r_hita ? r_ta : '0;
        o_point_x  <= r_hita ? w_cx : '0;
        o_point_y  <= r_hita ? w_cy : '0;
        o_point_z  <= r_hita ? w_cz : '0;
        o_overflow <= r_hita && (r_ovfa || w_ox || w_oy || w_oz);
    end

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_distance == '0 && !o_overflow)
        else $error("miss carries data");
    a_strobe_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ##(QW+2) o_strobe)
        else $error("result lost");
`endif
endmodule
